[rtl/tcw_pkg.sv]
// Shared constants, types and helper functions for the text console writer.
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SETCUR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    // Cell layout: background in bits 15..12, foreground in 11..8, character in 7..0.
    function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                    input logic [3:0] fg,
                                                    input logic [3:0] bg);
        return {bg, fg, ch};
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

[rtl/tcw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // Read data holds its value between reads.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer: cell store sequencer and cursor.
//
// Usage: one command beat enters on the input channel (in_valid/in_stall) and
// exactly one result beat leaves on the output channel (out_valid/out_stall).
// A command is taken when in_valid is high and in_stall is low. The result
// carries the cursor position after the command and, for a cell read, the
// stored cell; the cell fields are zero for the other commands.
// Sequencing: a put-char, newline, set-cursor or read-cell passes through
// EXEC and FINISH before its result is valid, and the next command can be
// taken once the sequencer is back in IDLE. Clear screen walks the whole
// store with the single RAM write port. A put or newline that runs past
// the last cell scrolls: one copy pass over the first ROWS-1 rows (one read
// and one write per cycle), a drain state, and one blanking pass over the
// last row. The RAM write port paces these passes.
// Reset homes the cursor and empties the output register; the cell store is
// not cleared, so a cell must be written before it is read.
// When the receiver stalls, the finished result stays in the output register;
// one further command may be accepted and run, but its result waits until
// the output register is free.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic [7:0]       char_code,
    input  logic [3:0]       fg_colour,
    input  logic [3:0]       bg_colour,
    input  logic [COL_W-1:0] target_col,
    input  logic [ROW_W-1:0] target_row,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ROW_W-1:0] cursor_row,
    output logic [COL_W-1:0] cursor_col,
    output logic [7:0]       cell_char,
    output logic [3:0]       cell_fg,
    output logic [3:0]       cell_bg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [7:0]        char_reg, char_next;
    logic [3:0]        fg_reg, fg_next;
    logic [3:0]        bg_reg, bg_next;
    logic [COL_W-1:0]  tcol_reg, tcol_next;
    logic [ROW_W-1:0]  trow_reg, trow_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              dly_wr_reg, dly_wr_next;
    logic [ADDR_W-1:0] dly_addr_reg, dly_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [3:0]        out_fg_reg, out_fg_next;
    logic [3:0]        out_bg_reg, out_bg_next;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    logic              in_accept;
    logic [COL_W-1:0]  clamp_col;
    logic [ROW_W-1:0]  clamp_row;
    logic [CELL_W-1:0] blank_cell;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_char  = out_char_reg;
    assign cell_fg    = out_fg_reg;
    assign cell_bg    = out_bg_reg;

    // Targets beyond the screen saturate to the last column or row.
    assign clamp_col  = (tcol_reg > LAST_COL) ? LAST_COL : tcol_reg;
    assign clamp_row  = (trow_reg > LAST_ROW) ? LAST_ROW : trow_reg;
    assign blank_cell = make_cell(BLANK_CHAR, fg_reg, bg_reg);

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        char_next      = char_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        tcol_next      = tcol_reg;
        trow_next      = trow_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        dly_wr_next    = 1'b0;
        dly_addr_next  = dly_addr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_char_next  = out_char_reg;
        out_fg_next    = out_fg_reg;
        out_bg_next    = out_bg_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg;
        ram_wr_data = blank_cell;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_reg;

        // The delayed copy write lands in the cycle after its read was issued.
        if (dly_wr_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dly_addr_reg;
            ram_wr_data = ram_rd_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    func_next  = func_t'(func);
                    char_next  = char_code;
                    fg_next    = fg_colour;
                    bg_next    = bg_colour;
                    tcol_next  = target_col;
                    trow_next  = target_row;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FINISH;
                case (func_reg)
                    FUNC_PUT:
                    begin
                        if (char_reg != NEWLINE_CODE)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = cell_addr(row_reg, col_reg);
                            ram_wr_data = make_cell(char_reg, fg_reg, bg_reg);
                        end
                        if (char_reg != NEWLINE_CODE && col_reg != LAST_COL)
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                        else
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                // Ran past the last cell: scroll the screen up.
                                cnt_next   = ROW_STRIDE;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    FUNC_SETCUR:
                    begin
                        row_next = clamp_row;
                        col_next = clamp_col;
                    end
                    FUNC_READ:
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cell_addr(clamp_row, clamp_col);
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_COPY:
            begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = cnt_reg;
                dly_wr_next   = 1'b1;
                dly_addr_next = cnt_reg - ROW_STRIDE;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                cnt_next   = LAST_ROW_BASE;
                state_next = ST_BLANK;
            end
            ST_BLANK, ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg;
                ram_wr_data = blank_cell;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    if (func_reg == FUNC_READ)
                    begin
                        out_char_next = ram_rd_data[7:0];
                        out_fg_next   = ram_rd_data[11:8];
                        out_bg_next   = ram_rd_data[15:12];
                    end
                    else
                    begin
                        out_char_next = '0;
                        out_fg_next   = '0;
                        out_bg_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FUNC_PUT;
            char_reg      <= '0;
            fg_reg        <= '0;
            bg_reg        <= '0;
            tcol_reg      <= '0;
            trow_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            dly_wr_reg    <= 1'b0;
            dly_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_char_reg  <= '0;
            out_fg_reg    <= '0;
            out_bg_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            char_reg      <= char_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            tcol_reg      <= tcol_next;
            trow_reg      <= trow_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cnt_reg       <= cnt_next;
            dly_wr_reg    <= dly_wr_next;
            dly_addr_reg  <= dly_addr_next;
            out_valid_reg <= out_valid_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_char_reg  <= out_char_next;
            out_fg_reg    <= out_fg_next;
            out_bg_reg    <= out_bg_next;
        end
    end

    // The cursor never leaves the screen.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("cursor outside the screen");

    // Every store write stays inside the store.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (ram_wr_addr <= LAST_ADDR))
        else $error("store write beyond the last cell");

    // A delayed copy write only follows a copy read.
    a_copy_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        dly_wr_reg |-> (state_reg == ST_COPY || state_reg == ST_DRAIN))
        else $error("copy write outside the scroll pass");

    // A new result appears only when the sequencer finishes a command.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result without a finished command");

    // An accepted command always starts execution on the next cycle.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_EXEC))
        else $error("accepted command did not start");

endmodule

[tb/sv/text_console_writer_tb.sv]
// Self-checking testbench for the text console writer: directed and random command traffic.
module text_console_writer_tb;
    import tcw_pkg::*;

    // A scroll or a clear walks the whole store, so a quiet stretch
    // lasting a full pass is normal. Allow ten passes' worth before
    // the run is declared hung.
    localparam int WATCHDOG_CYCLES = 10 * CELLS + 1000;
    localparam int MAX_PRINTED_ERRORS = 40;

    // One expected result beat, field for field as it leaves the block.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       ch;
        logic [3:0]       fg;
        logic [3:0]       bg;
    } console_result_t;

    // Clock, reset and every input of the block start at known values.
    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic [1:0]       func       = FUNC_PUT;
    logic [7:0]       char_code  = 8'd0;
    logic [3:0]       fg_colour  = 4'd0;
    logic [3:0]       bg_colour  = 4'd0;
    logic [COL_W-1:0] target_col = '0;
    logic [ROW_W-1:0] target_row = '0;
    logic             out_stall  = 1'b0;

    logic             in_stall;
    logic             out_valid;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [7:0]       cell_char;
    logic [3:0]       cell_fg;
    logic [3:0]       cell_bg;

    text_console_writer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .char_code  (char_code),
        .fg_colour  (fg_colour),
        .bg_colour  (bg_colour),
        .target_col (target_col),
        .target_row (target_row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_char  (cell_char),
        .cell_fg    (cell_fg),
        .cell_bg    (cell_bg)
    );

    always #5 clk = ~clk;

    // Shadow copy of the console: the screen contents, which cells hold
    // real data, and the cursor as a linear offset (row * COLUMNS + col).
    logic [CELL_W-1:0] screen_shadow [CELLS];
    bit                cell_written  [CELLS];
    int unsigned       cursor_pos;

    // Results predicted for accepted commands, oldest first.
    console_result_t pending_results[$];

    // Idle and stall percentages for the two sides; changed between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int error_count    = 0;
    int results_seen   = 0;
    int put_count      = 0;
    int newline_count  = 0;
    int clear_count    = 0;
    int move_count     = 0;
    int read_count     = 0;
    int scroll_count   = 0;

    // Handshake observations. Both channels are sampled mid-cycle, where
    // inputs driven at the last rising edge and registered outputs are
    // settled, so the next rising edge accepts exactly what was seen here.
    bit               in_take  = 1'b0;
    bit               out_take = 1'b0;
    console_result_t  seen_result;

    always @(negedge clk)
    begin
        in_take     = rst_n && in_valid && !in_stall;
        out_take    = rst_n && out_valid && !out_stall;
        seen_result = '{cursor_row, cursor_col, cell_char, cell_fg, cell_bg};
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= MAX_PRINTED_ERRORS)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Turns a target into a linear offset, saturating each coordinate at
    // the screen edge just as set cursor and read cell do.
    function automatic int unsigned clamped_offset(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
        int unsigned c;
        int unsigned r;
        c = (col > COLUMNS - 1) ? COLUMNS - 1 : col;
        r = (row > ROWS - 1) ? ROWS - 1 : row;
        return r * COLUMNS + c;
    endfunction

    // Moves every row up by one, blanks the last row in the given colours
    // and parks the cursor at the start of the last row.
    function automatic void scroll_shadow(input logic [3:0] fg, input logic [3:0] bg);
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
        begin
            screen_shadow[i] = screen_shadow[i + COLUMNS];
            cell_written[i]  = cell_written[i + COLUMNS];
        end
        for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
        begin
            screen_shadow[i] = {bg, fg, BLANK_CHAR};
            cell_written[i]  = 1'b1;
        end
        cursor_pos = (ROWS - 1) * COLUMNS;
        scroll_count++;
    endfunction

    // Applies one command to the shadow console and returns the result
    // beat the block must produce for it.
    function automatic console_result_t run_console_command(
        input func_t f, input logic [7:0] ch, input logic [3:0] fg, input logic [3:0] bg,
        input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        console_result_t   res;
        logic [CELL_W-1:0] read_word;
        res       = '0;
        read_word = '0;
        case (f)
            FUNC_PUT:
            begin
                if (ch == NEWLINE_CODE)
                    cursor_pos += COLUMNS - (cursor_pos % COLUMNS);
                else
                begin
                    screen_shadow[cursor_pos] = {bg, fg, ch};
                    cell_written[cursor_pos]  = 1'b1;
                    cursor_pos++;
                end
                if (cursor_pos >= CELLS)
                    scroll_shadow(fg, bg);
            end
            FUNC_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen_shadow[i] = {bg, fg, BLANK_CHAR};
                    cell_written[i]  = 1'b1;
                end
                cursor_pos = 0;
            end
            FUNC_SETCUR:
                cursor_pos = clamped_offset(col, row);
            default:
                read_word = screen_shadow[clamped_offset(col, row)];
        endcase
        res.row = ROW_W'(cursor_pos / COLUMNS);
        res.col = COL_W'(cursor_pos % COLUMNS);
        res.ch  = read_word[7:0];
        res.fg  = read_word[11:8];
        res.bg  = read_word[15:12];
        return res;
    endfunction

    // Sends one command beat. The sender may idle first; valid is only
    // lowered on an idle cycle, never at the step that raises it again.
    // After the accepting edge valid stays high so that back-to-back beats
    // need no second assignment in the same step.
    task automatic send_command(input func_t f, input logic [7:0] ch,
                                input logic [3:0] fg, input logic [3:0] bg,
                                input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        char_code  <= ch;
        fg_colour  <= fg;
        bg_colour  <= bg;
        target_col <= col;
        target_row <= row;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        // The beat is taken at this edge: predict its result now.
        pending_results.push_back(run_console_command(f, ch, fg, bg, col, row));
        case (f)
            FUNC_PUT:    if (ch == NEWLINE_CODE) newline_count++; else put_count++;
            FUNC_CLEAR:  clear_count++;
            FUNC_SETCUR: move_count++;
            default:     read_count++;
        endcase
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Output side: compare each accepted beat with the oldest prediction,
    // then choose the stall for the next cycle.
    initial
    begin : result_checker
        console_result_t want;
        forever
        begin
            @(posedge clk);
            if (out_take)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report_mismatch("result beat with no command outstanding", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (seen_result.row !== want.row)
                        report_mismatch("cursor_row", seen_result.row, want.row);
                    if (seen_result.col !== want.col)
                        report_mismatch("cursor_col", seen_result.col, want.col);
                    if (seen_result.ch !== want.ch)
                        report_mismatch("cell_char", seen_result.ch, want.ch);
                    if (seen_result.fg !== want.fg)
                        report_mismatch("cell_fg", seen_result.fg, want.fg);
                    if (seen_result.bg !== want.bg)
                        report_mismatch("cell_bg", seen_result.bg, want.bg);
                end
            end
            out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Hang detector: counts consecutive cycles in which neither channel
    // moves a beat. Reaching the limit ends the run as a failure.
    initial
    begin : hang_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (in_take || out_take)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_CYCLES, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

    // Fresh from reset the cursor is home. Write a few characters with
    // extreme codes and colours, read them back, take a newline, and check
    // that a column beyond the edge saturates while the row is kept.
    task automatic test_put_and_read();
        send_command(FUNC_PUT, 8'h41, 4'hF, 4'h0, '0, '0);
        send_command(FUNC_PUT, 8'hFF, 4'h0, 4'hF, '0, '0);
        send_command(FUNC_PUT, 8'h00, 4'hA, 4'h5, '0, '0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd1, 5'd0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd2, 5'd0);
        send_command(FUNC_PUT, NEWLINE_CODE, 4'h3, 4'hC, '0, '0);
        send_command(FUNC_SETCUR, 8'h00, 4'h0, 4'h0, 7'd100, 5'd3);
        // The cursor sits on the last column, so this wraps to the next row.
        send_command(FUNC_PUT, 8'h71, 4'h5, 4'hA, '0, '0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd127, 5'd3);
    endtask

    // Clear the screen, then push both coordinates past their limits for
    // a cursor move and a read, and read the opposite corner too.
    task automatic test_clear_and_saturation();
        send_command(FUNC_CLEAR, 8'h00, 4'h7, 4'h1, 7'd127, 5'd31);
        send_command(FUNC_SETCUR, 8'h00, 4'h0, 4'h0, 7'd127, 5'd31);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd127, 5'd31);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0);
    endtask

    // Writing the very last cell scrolls the screen; so does a newline on
    // the last row. Read back the shifted character and the blanked row.
    task automatic test_scroll();
        send_command(FUNC_SETCUR, 8'h00, 4'h0, 4'h0, 7'd79, 5'd24);
        send_command(FUNC_PUT, 8'h5A, 4'hE, 4'h2, '0, '0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd23);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd24);
        send_command(FUNC_PUT, 8'h78, 4'h9, 4'h6, '0, '0);
        send_command(FUNC_PUT, NEWLINE_CODE, 4'h4, 4'hB, '0, '0);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd22);
        send_command(FUNC_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd23);
    endtask

    // Random traffic. Text puts dominate, with newlines mixed in; cursor
    // moves lean toward the bottom row so that scrolls come often; half of the
    // reads check the cell just written, the rest hit anywhere, including
    // targets beyond the edges. Clears are rare because each costs a full
    // pass over the store.
    task automatic test_random_traffic(input int count);
        int unsigned      pick;
        int unsigned      target;
        func_t            f;
        logic [7:0]       ch;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            col  = COL_W'($urandom_range(127));
            row  = ROW_W'($urandom_range(31));
            if (pick < 2)
                f = FUNC_CLEAR;
            else if (pick < 52)
            begin
                f = FUNC_PUT;
                if ($urandom_range(99) < 15)
                    ch = NEWLINE_CODE;
            end
            else if (pick < 67)
            begin
                f = FUNC_SETCUR;
                if ($urandom_range(99) < 35)
                    row = ROW_W'($urandom_range(31, ROWS - 1));
            end
            else
            begin
                f = FUNC_READ;
                if ($urandom_range(1) == 1 && cursor_pos > 0)
                begin
                    target = cursor_pos - 1;
                    col    = COL_W'(target % COLUMNS);
                    row    = ROW_W'(target / COLUMNS);
                end
                // Never read a cell that holds nothing yet; move instead.
                if (!cell_written[clamped_offset(col, row)])
                    f = FUNC_SETCUR;
            end
            send_command(f, ch, 4'($urandom_range(15)), 4'($urandom_range(15)), col, row);
        end
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The shadow starts like the block: cursor home, no cell written.
        cursor_pos = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            screen_shadow[i] = '0;
            cell_written[i]  = 1'b0;
        end

        // Phase one: light sender gaps, heavy receiver back-pressure.
        send_idle_pct  = 19;
        recv_stall_pct = 56;
        test_put_and_read();
        // Let everything drain before the clear so nothing is in flight.
        wait_results_drained();
        test_clear_and_saturation();
        test_scroll();
        test_random_traffic(150);

        // Phase two: the sides swap roles.
        wait_results_drained();
        send_idle_pct  = 56;
        recv_stall_pct = 19;
        test_random_traffic(170);

        // Phase three: full speed on both sides.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(170);

        wait_results_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d character puts, %0d newlines, %0d clears, %0d cursor moves, %0d reads",
                 put_count, newline_count, clear_count, move_count, read_count);
        $display("Screen scrolled %0d times; %0d result beats compared, %0d mismatches",
                 scroll_count, results_seen, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
